FILE: hdl/encoder_prop_walk_rpm_meter_top_assert.svh
// Assertion macros shared by the thruster encoder RTL.
`ifndef ENCODER_PROP_WALK_RPM_METER_TOP_ASSERT_SVH
`define ENCODER_PROP_WALK_RPM_METER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define EPWRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet in reset
`define EPWRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/epwrm_pkg.sv
// Shared constants, codes and interface types of the thruster encoder block.
package epwrm_pkg;

  localparam int WINDOW_EDGES  = 10;
  localparam int EDGE_W        = $clog2(WINDOW_EDGES + 1) + 1;
  localparam int RPM_SCALE     = 3000;
  localparam int RPM_MAX       = 30000;
  localparam int NUM_W         = $clog2(RPM_SCALE * WINDOW_EDGES + 1);
  localparam int CNT_W         = $clog2(NUM_W);
  localparam int TICKS_PER_SEC = 100;
  localparam int ELAPSED_W     = 40;

  localparam logic signed [EDGE_W-1:0] EDGE_LIMIT = EDGE_W'(WINDOW_EDGES);
  localparam logic signed [EDGE_W-1:0] EDGE_ONE   = EDGE_W'(1);
  localparam logic signed [EDGE_W-1:0] EDGE_SKIP  = '1;

  localparam logic [6:0]        SLOW_RESET = 7'd30;
  localparam logic [6:0]        DRIVE_FULL = 7'd100;
  localparam logic signed [7:0] THRUST_MAX = 8'sd100;
  localparam logic signed [7:0] THRUST_MIN = -8'sd100;
  localparam logic signed [1:0] WALK_POS   = 2'sb01;
  localparam logic signed [1:0] WALK_NEG   = 2'sb11;

  typedef enum logic [2:0] {
    ACT_SAMPLE     = 3'd0,
    ACT_THRUST     = 3'd1,
    ACT_CLEAR_REVS = 3'd2,
    ACT_WINDOW     = 3'd3,
    ACT_READ       = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    STAT_ACCURATE   = 2'd0,
    STAT_INACCURATE = 2'd1,
    STAT_OPEN       = 2'd2
  } rpm_status_t;

  typedef struct packed {
    logic                     start;
    logic signed [EDGE_W-1:0] edges;
  } rpm_req_t;

  typedef struct packed {
    logic        done;
    logic [14:0] magnitude;
  } rpm_rsp_t;

endpackage

FILE: hdl/encoder_prop_walk_rpm_meter_top.sv
// Top level of the thruster encoder block: drive, prop walk, edge count, rpm window.
//
//  channel  direction  handshake            fields
//  in       sink       in_valid/in_stall    action .. walk_request
//  out      source     out_valid/out_stall  drive .. rpm_status
//  cfg      sink       cfg_valid/cfg_ready  cfg_data (slow_level)
//
//  Every action but a read on a closed window finishes in the cycle it is accepted; one result beat each.
//  A read on a closed window runs through the serial divider's diff, scale, divide and done states.
//  rst is synchronous, active high; slow_level returns to 30, the edge counters clear.
//  in_stall rises while a read is in the divider or an undelivered beat cannot drain.
//  cfg_ready is always high.
`include "encoder_prop_walk_rpm_meter_top_assert.svh"

module encoder_prop_walk_rpm_meter_top import epwrm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         action,
  input  logic               encoder_level,
  input  logic [31:0]        time_seconds,
  input  logic [6:0]         time_hundredths,
  input  logic signed [7:0]  thrust_request,
  input  logic signed [7:0]  walk_request,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  drive,
  output logic               drive_updated,
  output logic [15:0]        half_revs,
  output logic [14:0]        rpm_magnitude,
  output logic [1:0]         rpm_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);

  typedef enum logic [1:0] {
    TOP_IDLE = 2'b01,
    TOP_WAIT = 2'b10
  } top_state_t;

  top_state_t               state;
  logic [6:0]               slow_level;
  logic                     last_level;
  logic signed [7:0]        thrust_now;
  logic signed [1:0]        walk_now;
  logic signed [7:0]        drive_now;
  logic [15:0]              edge_total;
  logic                     window_open;
  logic signed [EDGE_W-1:0] window_edges;
  logic [31:0]              start_seconds;
  logic [6:0]               start_hundredths;
  logic [31:0]              end_seconds;
  logic [6:0]               end_hundredths;
  logic [1:0]               pend_status;

  logic                     last_level_next;
  logic signed [7:0]        thrust_now_next;
  logic signed [1:0]        walk_now_next;
  logic signed [7:0]        drive_now_next;
  logic [15:0]              edge_total_next;
  logic                     window_open_next;
  logic signed [EDGE_W-1:0] window_edges_next;
  logic [31:0]              start_seconds_next;
  logic [6:0]               start_hundredths_next;
  logic [31:0]              end_seconds_next;
  logic [6:0]               end_hundredths_next;

  logic                     in_accept;
  logic                     slot_free;
  logic                     updated;
  logic [1:0]               status_now;
  logic [1:0]               read_status;
  logic                     defer;
  logic [6:0]               slow_eff;
  logic                     pos;
  logic                     full_side;
  logic [6:0]               mag;
  rpm_req_t                 req;
  rpm_rsp_t                 rsp;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = !((state == TOP_IDLE) && slot_free);
  assign in_accept = in_valid && !in_stall;

  assign slow_eff  = (slow_level > DRIVE_FULL) ? DRIVE_FULL : slow_level;
  assign pos       = !thrust_now[7];
  assign full_side = (pos == encoder_level) ? (walk_now == WALK_POS) : walk_now[1];
  assign mag       = full_side ? DRIVE_FULL : slow_eff;
  assign read_status = (window_edges[0] || (window_edges < EDGE_LIMIT)) ?
                       STAT_INACCURATE : STAT_ACCURATE;

  always_comb begin
    last_level_next       = last_level;
    thrust_now_next       = thrust_now;
    walk_now_next         = walk_now;
    drive_now_next        = drive_now;
    edge_total_next       = edge_total;
    window_open_next      = window_open;
    window_edges_next     = window_edges;
    start_seconds_next    = start_seconds;
    start_hundredths_next = start_hundredths;
    end_seconds_next      = end_seconds;
    end_hundredths_next   = end_hundredths;
    updated               = 1'b0;
    status_now            = STAT_ACCURATE;
    defer                 = 1'b0;
    if (in_accept) begin
      unique case (action_t'(action))
        ACT_SAMPLE: begin
          if ((thrust_now != '0) && (encoder_level != last_level)) begin
            last_level_next = encoder_level;
            if (window_open) begin
              if (window_edges == '0) begin
                start_seconds_next    = time_seconds;
                start_hundredths_next = time_hundredths;
              end else begin
                end_seconds_next    = time_seconds;
                end_hundredths_next = time_hundredths;
              end
              if (window_edges == EDGE_LIMIT) begin
                window_open_next = 1'b0;
              end else begin
                window_edges_next = window_edges + EDGE_ONE;
              end
            end
            edge_total_next = edge_total + 16'd1;
            if (walk_now != '0) begin
              drive_now_next = pos ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
              updated        = 1'b1;
            end
          end
        end
        ACT_THRUST: begin
          priority if (thrust_request > THRUST_MAX) thrust_now_next = THRUST_MAX;
          else if (thrust_request < THRUST_MIN) thrust_now_next = THRUST_MIN;
          else thrust_now_next = thrust_request;
          priority if (walk_request > 8'sd0) walk_now_next = WALK_POS;
          else if (walk_request < 8'sd0) walk_now_next = WALK_NEG;
          else walk_now_next = 2'sb00;
          drive_now_next = thrust_now_next;
          updated        = 1'b1;
        end
        ACT_CLEAR_REVS: begin
          edge_total_next = '0;
        end
        ACT_WINDOW: begin
          start_seconds_next    = '0;
          start_hundredths_next = '0;
          end_seconds_next      = '0;
          end_hundredths_next   = '0;
          window_edges_next     = EDGE_SKIP;
          window_open_next      = 1'b1;
        end
        ACT_READ: begin
          if (window_open) begin
            status_now = STAT_OPEN;
          end else begin
            defer = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= TOP_IDLE;
      slow_level       <= SLOW_RESET;
      last_level       <= 1'b0;
      thrust_now       <= '0;
      walk_now         <= '0;
      drive_now        <= '0;
      edge_total       <= '0;
      window_open      <= 1'b0;
      window_edges     <= '0;
      start_seconds    <= '0;
      start_hundredths <= '0;
      end_seconds      <= '0;
      end_hundredths   <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) slow_level <= cfg_data;
      unique case (state)
        TOP_IDLE: if (in_accept && defer) state <= TOP_WAIT;
        TOP_WAIT: if (rsp.done) state <= TOP_IDLE;
        default:  state <= TOP_IDLE;
      endcase
      last_level       <= last_level_next;
      thrust_now       <= thrust_now_next;
      walk_now         <= walk_now_next;
      drive_now        <= drive_now_next;
      edge_total       <= edge_total_next;
      window_open      <= window_open_next;
      window_edges     <= window_edges_next;
      start_seconds    <= start_seconds_next;
      start_hundredths <= start_hundredths_next;
      end_seconds      <= end_seconds_next;
      end_hundredths   <= end_hundredths_next;
      priority if (in_accept && !defer) out_valid <= 1'b1;
      else if (rsp.done) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && defer) pend_status <= read_status;
    priority if (in_accept && !defer) begin
      drive         <= drive_now_next;
      drive_updated <= updated;
      half_revs     <= edge_total_next;
      rpm_magnitude <= '0;
      rpm_status    <= status_now;
    end else if (rsp.done) begin
      drive         <= drive_now;
      drive_updated <= 1'b0;
      half_revs     <= edge_total;
      rpm_magnitude <= rsp.magnitude;
      rpm_status    <= pend_status;
    end
  end

  assign req.start = in_accept && defer;
  assign req.edges = window_edges;

  epwrm_rpm_calc u_rpm_calc (
    .clk              (clk),
    .rst              (rst),
    .req              (req),
    .start_seconds    (start_seconds),
    .start_hundredths (start_hundredths),
    .end_seconds      (end_seconds),
    .end_hundredths   (end_hundredths),
    .rsp              (rsp)
  );

  `EPWRM_ASSERT_NOW(a_result_slot_empty, rsp.done, !out_valid, "rpm result over pending beat")
  `EPWRM_ASSERT_NOW(a_wait_window_closed, state == TOP_WAIT, !window_open && in_stall,
                    "window moved during read")
  `EPWRM_ASSERT_NOW(a_closed_count, !window_open,
                    (window_edges == '0) || (window_edges == EDGE_LIMIT),
                    "closed window with odd count")

endmodule

FILE: hdl/epwrm_rpm_calc.sv
// Elapsed-time scaling and bit-serial restoring divider for the rpm figure.
`include "encoder_prop_walk_rpm_meter_top_assert.svh"

module epwrm_rpm_calc import epwrm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rpm_req_t    req,
  input  logic [31:0] start_seconds,
  input  logic [6:0]  start_hundredths,
  input  logic [31:0] end_seconds,
  input  logic [6:0]  end_hundredths,
  output rpm_rsp_t    rsp
);

  typedef enum logic [4:0] {
    CALC_IDLE   = 5'b00001,
    CALC_DIFF   = 5'b00010,
    CALC_SCALE  = 5'b00100,
    CALC_DIVIDE = 5'b01000,
    CALC_DONE   = 5'b10000
  } calc_state_t;

  calc_state_t                 state;
  calc_state_t                 state_next;
  logic [NUM_W-1:0]            num_sh;
  logic [NUM_W-1:0]            rem;
  logic [NUM_W-1:0]            divisor;
  logic [CNT_W-1:0]            cnt;
  logic                        n_pos;
  logic                        zero_q;
  logic [31:0]                 diff_s;
  logic [7:0]                  diff_h;
  logic [ELAPSED_W-1:0]        elapsed;
  logic                        elapsed_ok;
  logic [NUM_W:0]              trial;
  logic                        ge;
  logic                        sat;

  assign elapsed = ELAPSED_W'(diff_s) * ELAPSED_W'(TICKS_PER_SEC)
                 + {{(ELAPSED_W-8){diff_h[7]}}, diff_h};
  assign elapsed_ok = !elapsed[ELAPSED_W-1] && (elapsed != '0)
                    && (elapsed[ELAPSED_W-1:NUM_W] == '0);
  assign trial = {rem, num_sh[NUM_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign sat   = 32'(num_sh) > 32'(RPM_MAX);

  always_comb begin
    state_next = state;
    unique case (state)
      CALC_IDLE:   if (req.start) state_next = CALC_DIFF;
      CALC_DIFF:   state_next = CALC_SCALE;
      CALC_SCALE:  state_next = CALC_DIVIDE;
      CALC_DIVIDE: if (cnt == '0) state_next = CALC_DONE;
      CALC_DONE:   state_next = CALC_IDLE;
      default:     state_next = CALC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CALC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      CALC_IDLE: begin
        n_pos  <= !req.edges[EDGE_W-1] && (req.edges != '0);
        num_sh <= NUM_W'(32'(req.edges[EDGE_W-2:0]) * 32'(RPM_SCALE));
      end
      CALC_DIFF: begin
        diff_s <= end_seconds - start_seconds;
        diff_h <= {1'b0, end_hundredths} - {1'b0, start_hundredths};
      end
      CALC_SCALE: begin
        divisor <= elapsed[NUM_W-1:0];
        zero_q  <= !(n_pos && elapsed_ok);
        rem     <= '0;
        cnt     <= CNT_W'(NUM_W - 1);
      end
      CALC_DIVIDE: begin
        rem    <= ge ? NUM_W'(trial - {1'b0, divisor}) : trial[NUM_W-1:0];
        num_sh <= {num_sh[NUM_W-2:0], ge};
        cnt    <= cnt - CNT_W'(1);
      end
      CALC_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign rsp.done      = (state == CALC_DONE);
  assign rsp.magnitude = zero_q ? 15'd0 : (sat ? 15'(RPM_MAX) : 15'(num_sh));

  `EPWRM_ASSERT_NOW(a_start_when_idle, req.start, state == CALC_IDLE, "start while busy")
  `EPWRM_ASSERT_NEXT(a_divide_ends, (state == CALC_DIVIDE) && (cnt == '0), state == CALC_DONE,
                     "divide overran")
  `EPWRM_ASSERT_NEXT(a_done_single, state == CALC_DONE, state == CALC_IDLE, "done held")

endmodule

FILE: verif/tb_top.sv
// Testbench for the thruster encoder block: directed and random beats checked against a local model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import epwrm_pkg::*;

  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic [6:0] SLOW_TOP     = 7'h7F;
  localparam int RANDOM_ITEMS = 1750;
  localparam int QUIET_FROM   = 1500;
  localparam int BURST_EDGES  = 40;
  localparam int SETTLE       = NUM_W + 8;
  localparam int WATCH_LIMIT  = 2000;

  typedef enum int {
    STAMP_STEADY, STAMP_FROZEN, STAMP_SCATTER, STAMP_WRAP, STAMP_FAST, STAMP_CRAWL
  } stamp_mode_t;

  typedef struct packed {
    logic signed [7:0] drive;
    logic              updated;
    logic [15:0]       revs;
    logic [14:0]       rpm;
    logic [1:0]        status;
  } reading_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        action;
  logic              encoder_level;
  logic [31:0]       time_seconds;
  logic [6:0]        time_hundredths;
  logic signed [7:0] thrust_request;
  logic signed [7:0] walk_request;
  logic              out_valid;
  logic              out_stall;
  logic signed [7:0] drive;
  logic              drive_updated;
  logic [15:0]       half_revs;
  logic [14:0]       rpm_magnitude;
  logic [1:0]        rpm_status;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [6:0]        cfg_data;

  // local copy of the block state
  logic [6:0]        slow_cfg = SLOW_RESET;
  logic              lvl_now = 1'b0;
  logic signed [7:0] thrust_mdl = '0;
  logic signed [1:0] walk_set = '0;
  logic signed [7:0] drive_set = '0;
  logic [15:0]       revs_cnt = '0;
  logic              win_open = 1'b0;
  int                win_edges = 0;
  logic [31:0]       win_start_s = '0;
  logic [31:0]       win_end_s = '0;
  logic [6:0]        win_start_h = '0;
  logic [6:0]        win_end_h = '0;

  reading_t    pending_readings[$];
  bit          idle_on = 1'b1;
  logic [31:0] now_s = '0;
  logic [6:0]  now_h = '0;
  int beats_used, results_seen, mismatches, quiet_cycles;
  int reads_seen, accurate_reads, saturated_reads, cfg_writes;

  encoder_prop_walk_rpm_meter_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .encoder_level  (encoder_level),
    .time_seconds   (time_seconds),
    .time_hundredths(time_hundredths),
    .thrust_request (thrust_request),
    .walk_request   (walk_request),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive          (drive),
    .drive_updated  (drive_updated),
    .half_revs      (half_revs),
    .rpm_magnitude  (rpm_magnitude),
    .rpm_status     (rpm_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic predict_thruster(input logic [2:0] act, input logic lvl,
                                  input logic [31:0] secs, input logic [6:0] hund,
                                  input logic signed [7:0] thr, input logic signed [7:0] wlk);
    reading_t    r;
    int          slow, mag, n, t, w;
    longint      elapsed, ratio;
    logic [31:0] sdiff;
    r = '0;
    case (act)
      ACT_SAMPLE: begin
        if (thrust_mdl != 0 && lvl != lvl_now) begin
          lvl_now = lvl;
          if (win_open) begin
            if (win_edges == 0) begin
              win_start_s = secs;
              win_start_h = hund;
            end else begin
              win_end_s = secs;
              win_end_h = hund;
            end
            if (win_edges == WINDOW_EDGES) win_open = 1'b0;
            else win_edges++;
          end
          revs_cnt++;
          if (walk_set != 0) begin
            slow = (slow_cfg > DRIVE_FULL) ? 100 : int'(slow_cfg);
            if ((thrust_mdl > 0) == lvl) mag = (walk_set > 0) ? 100 : slow;
            else mag = (walk_set < 0) ? 100 : slow;
            drive_set = (thrust_mdl > 0) ? 8'(mag) : 8'(-mag);
            r.updated = 1'b1;
          end
        end
      end
      ACT_THRUST: begin
        t = int'(thr);
        w = int'(wlk);
        t = (t < -100) ? -100 : ((t > 100) ? 100 : t);
        w = (w < -1) ? -1 : ((w > 1) ? 1 : w);
        thrust_mdl = 8'(t);
        walk_set = 2'(w);
        drive_set = thrust_mdl;
        r.updated = 1'b1;
      end
      ACT_CLEAR_REVS: revs_cnt = '0;
      ACT_WINDOW: begin
        win_start_s = '0;
        win_start_h = '0;
        win_end_s = '0;
        win_end_h = '0;
        win_edges = -1;
        win_open = 1'b1;
      end
      ACT_READ: begin
        reads_seen++;
        if (win_open) begin
          r.status = STAT_OPEN;
        end else begin
          sdiff = win_end_s - win_start_s;
          elapsed = longint'({32'd0, sdiff}) * 100
                  + longint'({25'd0, win_end_h}) - longint'({25'd0, win_start_h});
          n = win_edges;
          if (n > 0 && elapsed > 0) begin
            ratio = longint'(RPM_SCALE * n) / elapsed;
            if (ratio >= RPM_MAX) saturated_reads++;
            r.rpm = 15'((ratio > RPM_MAX) ? RPM_MAX : ratio);
          end
          if ((n & 1) != 0 || n < WINDOW_EDGES) begin
            r.status = STAT_INACCURATE;
          end else begin
            r.status = STAT_ACCURATE;
            accurate_reads++;
          end
        end
      end
      default: ;
    endcase
    r.drive = drive_set;
    r.revs = revs_cnt;
    pending_readings.push_back(r);
    beats_used++;
  endtask

  task automatic send_beat(input logic [2:0] act, input logic lvl,
                           input logic [31:0] secs, input logic [6:0] hund,
                           input logic signed [7:0] thr, input logic signed [7:0] wlk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    action = act;
    encoder_level = lvl;
    time_seconds = secs;
    time_hundredths = hund;
    thrust_request = thr;
    walk_request = wlk;
    in_valid = 1'b1;
    predict_thruster(act, lvl, secs, hund, thr, wlk);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_edge(input logic [31:0] secs, input logic [6:0] hund);
    send_beat(ACT_SAMPLE, ~lvl_now, secs, hund, '0, '0);
  endtask

  task automatic set_slow_level(input logic [6:0] v);
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    slow_cfg = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic advance_stamp(input stamp_mode_t mode);
    int h;
    h = int'(now_h);
    case (mode)
      STAMP_FROZEN: ;
      STAMP_SCATTER: begin
        now_s = $urandom;
        h = $urandom_range(0, 127);
      end
      STAMP_FAST: h += $urandom_range(0, 1);
      STAMP_CRAWL: now_s += $urandom_range(0, 1000000);
      default: h += $urandom_range(1, 40);
    endcase
    if (mode != STAMP_SCATTER && h >= 100) begin
      h -= 100;
      now_s++;
    end
    now_h = 7'(h);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch on result %0d: %s is %0d, model says %0d", results_seen, what, got, want);
  endtask

  // check results and watch for a hang
  always @(posedge clk) begin
    reading_t want;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", WATCH_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_readings.size() == 0) begin
        report_mismatch("unrequested result, drive", longint'(drive), 0);
      end else begin
        want = pending_readings.pop_front();
        if (drive !== want.drive)
          report_mismatch("drive", longint'(drive), longint'(want.drive));
        if (drive_updated !== want.updated)
          report_mismatch("drive_updated", longint'(drive_updated), longint'(want.updated));
        if (half_revs !== want.revs)
          report_mismatch("half_revs", longint'(half_revs), longint'(want.revs));
        if (rpm_magnitude !== want.rpm)
          report_mismatch("rpm_magnitude", longint'(rpm_magnitude), longint'(want.rpm));
        if (rpm_status !== want.status)
          report_mismatch("rpm_status", longint'(rpm_status), longint'(want.status));
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) hold--;
      else if (idle_on && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 7);
      out_stall = (hold > 0);
    end
  end

  task automatic test_idle_behaviour;
    send_beat(ACT_READ, 1'b0, '0, '0, '0, '0);
    send_beat(ACT_SAMPLE, 1'b1, 32'hFFFF_FFFF, 7'h7F, '0, '0);
    for (int i = int'(ACT_SPARE_LO); i <= int'(ACT_SPARE_HI); i++)
      send_beat(3'(i), 1'($urandom), $urandom, 7'($urandom), 8'($urandom), 8'($urandom));
    send_beat(ACT_CLEAR_REVS, 1'b0, '0, '0, '0, '0);
  endtask

  task automatic test_thrust_clamp;
    send_beat(ACT_THRUST, 1'b0, '0, '0, 8'sd127, 8'sd127);
    send_edge('0, '0);
    send_beat(ACT_THRUST, 1'b0, '0, '0, -8'sd128, -8'sd128);
    send_edge('0, '0);
    send_beat(ACT_THRUST, 1'b0, '0, '0, 8'sd101, -8'sd2);
    send_beat(ACT_THRUST, 1'b0, '0, '0, -8'sd101, 8'sd2);
    send_beat(ACT_THRUST, 1'b0, '0, '0, 8'sd0, 8'sd1);
    send_edge('0, '0);
  endtask

  task automatic test_prop_walk;
    set_slow_level(7'd0);
    send_beat(ACT_THRUST, 1'b0, '0, '0, 8'sd60, 8'sd1);
    send_edge('0, '0);
    send_edge('0, '0);
    send_beat(ACT_THRUST, 1'b0, '0, '0, -8'sd60, -8'sd1);
    send_edge('0, '0);
    send_edge('0, '0);
    set_slow_level(SLOW_TOP);
    send_beat(ACT_THRUST, 1'b0, '0, '0, 8'sd60, -8'sd1);
    send_edge('0, '0);
    send_edge('0, '0);
    send_beat(ACT_THRUST, 1'b0, '0, '0, -8'sd60, 8'sd1);
    send_edge('0, '0);
    send_edge('0, '0);
    set_slow_level(DRIVE_FULL);
    send_beat(ACT_THRUST, 1'b0, '0, '0, 8'sd5, 8'sd0);
    send_edge('0, '0);
  endtask

  task automatic test_window_open_read;
    send_beat(ACT_WINDOW, 1'b0, '0, '0, '0, '0);
    send_beat(ACT_READ, 1'b0, '0, '0, '0, '0);
  endtask

  task automatic test_edge_burst;
    idle_on = 1'b0;
    send_beat(ACT_THRUST, 1'b0, '0, '0, 8'sd50, 8'sd0);
    send_beat(ACT_CLEAR_REVS, 1'b0, '0, '0, '0, '0);
    repeat (BURST_EDGES) send_edge('0, '0);
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic;
    stamp_mode_t      mode;
    logic [6:0]       slow_pick;
    logic signed [7:0] wlk;
    int               pick, n_edges, r;
    beats_used = 0;
    while (beats_used < RANDOM_ITEMS) begin
      if (beats_used >= QUIET_FROM) idle_on = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        if (thrust_mdl == 0 || $urandom_range(0, 3) == 0) begin
          wlk = ($urandom_range(0, 1) != 0) ? 8'($urandom)
                                            : 8'(int'($urandom_range(0, 2)) - 1);
          send_beat(ACT_THRUST, 1'b0, '0, '0, 8'($urandom), wlk);
        end
        mode = stamp_mode_t'($urandom_range(0, 5));
        if (mode == STAMP_WRAP) now_s = 32'hFFFF_FFFF - $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0) send_beat(ACT_CLEAR_REVS, 1'b0, '0, '0, '0, '0);
        send_beat(ACT_WINDOW, 1'b0, '0, '0, '0, '0);
        n_edges = $urandom_range(9, 14);
        repeat (n_edges) begin
          advance_stamp(mode);
          r = $urandom_range(0, 15);
          if (r == 0) send_beat(ACT_READ, 1'b0, '0, '0, '0, '0);
          else if (r == 1) send_beat(ACT_SAMPLE, lvl_now, now_s, now_h, '0, '0);
          send_edge(now_s, now_h);
        end
        send_beat(ACT_READ, 1'b0, '0, '0, '0, '0);
      end else begin
        repeat ($urandom_range(1, 8))
          send_beat(3'($urandom), 1'($urandom), $urandom, 7'($urandom),
                    8'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 3))
          0: slow_pick = 7'd0;
          1: slow_pick = DRIVE_FULL;
          2: slow_pick = SLOW_TOP;
          default: slow_pick = 7'($urandom);
        endcase
        set_slow_level(slow_pick);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_SAMPLE;
    encoder_level = 1'b0;
    time_seconds = '0;
    time_hundredths = '0;
    thrust_request = '0;
    walk_request = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_idle_behaviour();
    test_thrust_clamp();
    test_prop_walk();
    test_window_open_read();
    test_edge_burst();
    test_random_traffic();

    idle_on = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d results, %0d rpm reads (%0d accurate, %0d saturated)",
             results_seen, reads_seen, accurate_reads, saturated_reads);
    $display("slow_level written %0d times; edges also sent back to back without idling",
             cfg_writes);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
